### rtl/core/dpcl_pkg.sv
// dpcl_pkg: shared types and codes for the keypad pin command lock
// holds the configuration struct, the judge result struct and all code constants
// no dependencies
package dpcl_pkg;

  // default sizes handed to the top level parameters
  localparam int StoreCharsDef = 16;
  localparam int PinMaxDef     = 8;

  localparam int CodeW    = 4;
  localparam int PinLenW  = 4;
  localparam int ElapsedW = 15;
  localparam int FailW    = 8;

  // input opcodes
  localparam logic [1:0] OP_EVENT = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // event codes
  localparam logic [CodeW-1:0] CODE_STAR  = 4'd10;
  localparam logic [CodeW-1:0] CODE_HASH  = 4'd11;
  localparam logic [CodeW-1:0] DIGIT_DOOR  = 4'd1;
  localparam logic [CodeW-1:0] DIGIT_LIGHT = 4'd2;

  // result status
  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_REJECTED = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_IGNORED  = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  // actions
  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_DOOR  = 2'd1;
  localparam logic [1:0] ACT_LIGHT = 2'd2;

  // fail reasons
  localparam logic [2:0] FAIL_NONE   = 3'd0;
  localparam logic [2:0] FAIL_EMPTY  = 3'd1;
  localparam logic [2:0] FAIL_LEGACY = 3'd2;
  localparam logic [2:0] FAIL_LENGTH = 3'd3;
  localparam logic [2:0] FAIL_PIN    = 3'd4;
  localparam logic [2:0] FAIL_FORMAT = 3'd5;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_PIN_ENABLE    = 3'd0;
  localparam logic [2:0] REG_PIN_LENGTH    = 3'd1;
  localparam logic [2:0] REG_PIN_DIGITS    = 3'd2;
  localparam logic [2:0] REG_TIMEOUT_LIMIT = 3'd3;
  localparam logic [2:0] REG_ATTEMPT_LIMIT = 3'd4;

  localparam logic [ElapsedW-1:0] TIMEOUT_RESET = 15'd10000;
  localparam logic [FailW-1:0]    ATTEMPT_RESET = 8'd3;
  localparam logic [ElapsedW-1:0] ELAPSED_MAX   = '1;
  localparam logic [FailW-1:0]    FAIL_MAX      = '1;

  typedef struct packed {
    logic                pin_enable;
    logic [PinLenW-1:0]  pin_length;
    logic [31:0]         pin_digits;
    logic [ElapsedW-1:0] timeout_limit_ms;
    logic [FailW-1:0]    attempt_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] reason;
  } judge_t;

endpackage

### rtl/core/dtmf_pin_command_lock.sv
// dtmf_pin_command_lock: keypad pin command lock on telephone event codes
// path: a transaction passes the input register, then the result register (2 registers)
// throughput: one transaction per cycle, set by the single-pass step between the
// input register and the result register; a waiting result stalls the step and the input
// reset: rst_ni async low clears control state and loads register defaults; the digit
// store has no reset and needs no clearing pass
module dtmf_pin_command_lock #(
  parameter int StoreChars = dpcl_pkg::StoreCharsDef,
  parameter int PinMax     = dpcl_pkg::PinMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  event_code_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [1:0]  action_o,
  output logic [2:0]  fail_reason_o,
  output logic        locked_out_o,
  output logic [7:0]  failed_count_o
);
  import dpcl_pkg::*;

  cfg_t cfg;

  dpcl_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  dpcl_core #(
    .StoreChars(StoreChars),
    .PinMax    (PinMax)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .event_code_i  (event_code_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .action_o      (action_o),
    .fail_reason_o (fail_reason_o),
    .locked_out_o  (locked_out_o),
    .failed_count_o(failed_count_o)
  );

endmodule

### rtl/core/dpcl_cfg.sv
// dpcl_cfg: apb-style configuration register file for the pin command lock
// depends on dpcl_pkg for the register indexes and the cfg_t struct
module dpcl_cfg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output dpcl_pkg::cfg_t       cfg_o
);
  import dpcl_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pin_enable       <= 1'b0;
      cfg_q.pin_length       <= '0;
      cfg_q.pin_digits       <= '0;
      cfg_q.timeout_limit_ms <= TIMEOUT_RESET;
      cfg_q.attempt_limit    <= ATTEMPT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PIN_ENABLE:    cfg_q.pin_enable       <= pwdata[0];
        REG_PIN_LENGTH:    cfg_q.pin_length       <= pwdata[PinLenW-1:0];
        REG_PIN_DIGITS:    cfg_q.pin_digits       <= pwdata;
        REG_TIMEOUT_LIMIT: cfg_q.timeout_limit_ms <= pwdata[ElapsedW-1:0];
        REG_ATTEMPT_LIMIT: cfg_q.attempt_limit    <= pwdata[FailW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PIN_ENABLE:    prdata = {31'd0, cfg_q.pin_enable};
      REG_PIN_LENGTH:    prdata = {{(32-PinLenW){1'b0}}, cfg_q.pin_length};
      REG_PIN_DIGITS:    prdata = cfg_q.pin_digits;
      REG_TIMEOUT_LIMIT: prdata = {{(32-ElapsedW){1'b0}}, cfg_q.timeout_limit_ms};
      REG_ATTEMPT_LIMIT: prdata = {{(32-FailW){1'b0}}, cfg_q.attempt_limit};
      default:           prdata = '0;
    endcase
  end

endmodule

### rtl/core/dpcl_judge.sv
// dpcl_judge: decodes a completed command held in the digit store
// depends on dpcl_pkg for codes, cfg_t and judge_t
module dpcl_judge #(
  parameter int StoreChars = dpcl_pkg::StoreCharsDef,
  parameter int PinMax     = dpcl_pkg::PinMaxDef,
  localparam int Depth     = StoreChars - 1,
  localparam int FillW     = $clog2(StoreChars)
) (
  input  logic [Depth-1:0][dpcl_pkg::CodeW-1:0] store_i,
  input  logic [FillW-1:0]                       fill_i,
  input  dpcl_pkg::cfg_t                         cfg_i,
  output dpcl_pkg::judge_t                       res_o
);
  import dpcl_pkg::*;

  logic [PinLenW-1:0] want;
  logic [FillW-1:0]   fill_m1;
  logic               mismatch;

  always_comb begin
    if (cfg_i.pin_length > PinLenW'(PinMax)) begin
      want = PinLenW'(PinMax);
    end else begin
      want = cfg_i.pin_length;
    end
    fill_m1  = fill_i - FillW'(1);
    mismatch = 1'b0;
    for (int i = 0; i < PinMax; i++) begin
      if ((PinLenW'(i) < want) && (store_i[i+1] != cfg_i.pin_digits[4*i +: 4])) begin
        mismatch = 1'b1;
      end
    end
  end

  always_comb begin
    res_o.action = ACT_NONE;
    res_o.reason = FAIL_NONE;
    priority if (fill_i == '0) begin
      res_o.reason = FAIL_EMPTY;
    end else if (fill_i == FillW'(2) && store_i[0] == CODE_STAR
                 && store_i[1] == DIGIT_LIGHT) begin
      // star-two wins even when it would match the pin
      res_o.action = ACT_LIGHT;
    end else if (store_i[0] != CODE_STAR) begin
      res_o.reason = FAIL_FORMAT;
    end else if (!cfg_i.pin_enable) begin
      if (fill_i == FillW'(2) && store_i[1] == DIGIT_DOOR) begin
        res_o.action = ACT_DOOR;
      end else begin
        res_o.reason = FAIL_LEGACY;
      end
    end else if (fill_m1 != FillW'(want)) begin
      res_o.reason = FAIL_LENGTH;
    end else if (mismatch) begin
      res_o.reason = FAIL_PIN;
    end else begin
      res_o.action = ACT_DOOR;
    end
  end

endmodule

### rtl/core/dpcl_core.sv
// dpcl_core: input register, sequence state, result register
// depends on dpcl_pkg and dpcl_judge
module dpcl_core #(
  parameter int StoreChars = dpcl_pkg::StoreCharsDef,
  parameter int PinMax     = dpcl_pkg::PinMaxDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpcl_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     opcode_i,
  input  logic [7:0]     event_code_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     status_o,
  output logic [1:0]     action_o,
  output logic [2:0]     fail_reason_o,
  output logic           locked_out_o,
  output logic [7:0]     failed_count_o
);
  import dpcl_pkg::*;

  localparam int Depth = StoreChars - 1;
  localparam int FillW = $clog2(StoreChars);
  localparam int IdxW  = $clog2(Depth);

  // input stage
  logic       in_valid_q;
  logic [1:0] opcode_q;
  logic [7:0] code_q;
  logic       advance;

  // sequence state
  logic [Depth-1:0][CodeW-1:0] store_q;
  logic [FillW-1:0]            fill_q, fill_d;
  logic [ElapsedW-1:0]         elapsed_q, elapsed_d;
  logic                        running_q, running_d;
  logic [FailW-1:0]            failures_q, failures_d, fail_inc;
  logic                        lockout_q, lockout_d;
  logic                        store_we;

  // result stage
  logic       out_valid_q;
  logic [2:0] status_q, status_d;
  logic [1:0] action_q, action_d;
  logic [2:0] reason_q, reason_d;

  judge_t judge;

  assign advance    = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      opcode_q <= opcode_i;
      code_q   <= event_code_i;
    end
  end

  dpcl_judge #(
    .StoreChars(StoreChars),
    .PinMax    (PinMax)
  ) u_judge (
    .store_i(store_q),
    .fill_i (fill_q),
    .cfg_i  (cfg_i),
    .res_o  (judge)
  );

  assign fail_inc = (failures_q != FAIL_MAX) ? failures_q + FailW'(1) : failures_q;

  always_comb begin
    fill_d     = fill_q;
    elapsed_d  = elapsed_q;
    running_d  = running_q;
    failures_d = failures_q;
    lockout_d  = lockout_q;
    store_we   = 1'b0;
    status_d   = ST_IGNORED;
    action_d   = ACT_NONE;
    reason_d   = FAIL_NONE;
    unique case (opcode_q)
      OP_TICK: begin
        if (running_q && elapsed_q != ELAPSED_MAX) begin
          elapsed_d = elapsed_q + ElapsedW'(1);
        end
        status_d = ST_DONE;
      end
      OP_RESET: begin
        fill_d     = '0;
        elapsed_d  = '0;
        running_d  = 1'b0;
        failures_d = '0;
        lockout_d  = 1'b0;
        status_d   = ST_DONE;
      end
      OP_EVENT: begin
        if (!lockout_q && code_q[7:CodeW] == '0) begin
          priority if (fill_q != '0 && running_q
                       && elapsed_q >= cfg_i.timeout_limit_ms) begin
            fill_d    = '0;
            elapsed_d = '0;
            running_d = 1'b0;
            status_d  = ST_TIMEOUT;
          end else if (code_q[CodeW-1:0] == CODE_HASH) begin
            action_d = judge.action;
            reason_d = judge.reason;
            if (judge.reason != FAIL_NONE) begin
              failures_d = fail_inc;
              if (fail_inc >= cfg_i.attempt_limit) begin
                lockout_d = 1'b1;
              end
              status_d = ST_REJECTED;
            end else begin
              status_d = ST_ACCEPTED;
            end
            fill_d    = '0;
            elapsed_d = '0;
            running_d = 1'b0;
          end else if (fill_q < FillW'(Depth)) begin
            // first stored code starts the timer
            if (fill_q == '0) begin
              running_d = 1'b1;
              elapsed_d = '0;
            end
            store_we = 1'b1;
            fill_d   = fill_q + FillW'(1);
            status_d = ST_STORED;
          end else begin
            fill_d    = '0;
            elapsed_d = '0;
            running_d = 1'b0;
            status_d  = ST_OVERFLOW;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      elapsed_q   <= '0;
      running_q   <= 1'b0;
      failures_q  <= '0;
      lockout_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        fill_q      <= fill_d;
        elapsed_q   <= elapsed_d;
        running_q   <= running_d;
        failures_q  <= failures_d;
        lockout_q   <= lockout_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // digit store carries no reset, only entries below the fill count are read
  always_ff @(posedge clk_i) begin
    if (advance && store_we) begin
      store_q[fill_q[IdxW-1:0]] <= code_q[CodeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      status_q <= status_d;
      action_q <= action_d;
      reason_q <= reason_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign action_o       = action_q;
  assign fail_reason_o  = reason_q;
  assign locked_out_o   = lockout_q;
  assign failed_count_o = failures_q;

endmodule

### test/testbench.sv
// testbench: self-checking bench for the keypad pin command lock
// drives keypad transactions and apb register writes, predicts every result in-line
// depends on dpcl_pkg and dtmf_pin_command_lock
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dpcl_pkg::*;

  localparam logic [1:0] OpSpare = 2'd3;
  localparam int KeyDepth = StoreCharsDef - 1;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 160;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] code;
  } keypad_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] action;
    logic [2:0] reason;
    logic       locked;
    logic [7:0] count;
  } lock_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  opcode_i;
  logic [7:0]  event_code_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  status_o;
  logic [1:0]  action_o;
  logic [2:0]  fail_reason_o;
  logic        locked_out_o;
  logic [7:0]  failed_count_o;

  dtmf_pin_command_lock dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .opcode_i, .event_code_i,
    .out_valid_o, .out_ready_i, .status_o, .action_o, .fail_reason_o,
    .locked_out_o, .failed_count_o
  );

  always #6 clk_i = ~clk_i;

  // shadow of the lock: configuration and command state
  cfg_t                lock_cfg;
  logic [3:0]          key_store [KeyDepth];
  int                  key_fill;
  logic [ElapsedW-1:0] elapsed;
  logic                timer_on;
  logic [FailW-1:0]    fail_count;
  logic                lock_flag;

  keypad_item_t pending_keys[$];
  lock_result_t expected_results[$];

  bit in_took;
  bit calm;
  bit hold_start;
  int hold_left;
  int stall_cycles;
  int mismatches;
  int pushed_n;
  int accepted_n;
  int results_n;
  int settings_n;
  int status_seen [8];

  function automatic void clear_entry();
    key_fill = 0;
    elapsed  = '0;
    timer_on = 1'b0;
  endfunction

  function automatic lock_result_t step_lock(logic [1:0] op, logic [7:0] code);
    lock_result_t r;
    logic [3:0]   want;
    bit           diff;
    r = '0;
    r.status = ST_IGNORED;
    if (op == OP_TICK) begin
      if (timer_on && elapsed != ELAPSED_MAX) elapsed++;
      r.status = ST_DONE;
    end else if (op == OP_RESET) begin
      clear_entry();
      fail_count = '0;
      lock_flag  = 1'b0;
      r.status   = ST_DONE;
    end else if (op == OP_EVENT && !lock_flag && code <= 8'd15) begin
      if (key_fill == 0) begin
        timer_on = 1'b1;
        elapsed  = '0;
      end
      if (key_fill != 0 && timer_on && elapsed >= lock_cfg.timeout_limit_ms) begin
        clear_entry();
        r.status = ST_TIMEOUT;
      end else if (code[3:0] == CODE_HASH) begin
        // judge the collected command
        if (key_fill == 0) begin
          r.reason = FAIL_EMPTY;
        end else if (key_fill == 2 && key_store[0] == CODE_STAR &&
                     key_store[1] == DIGIT_LIGHT) begin
          r.action = ACT_LIGHT;
        end else if (key_store[0] != CODE_STAR) begin
          r.reason = FAIL_FORMAT;
        end else if (!lock_cfg.pin_enable) begin
          if (key_fill == 2 && key_store[1] == DIGIT_DOOR) r.action = ACT_DOOR;
          else r.reason = FAIL_LEGACY;
        end else begin
          want = (lock_cfg.pin_length > PinMaxDef) ? 4'(PinMaxDef) : lock_cfg.pin_length;
          diff = 1'b0;
          for (int i = 0; i < PinMaxDef; i++) begin
            if (i < want && key_store[i + 1] != lock_cfg.pin_digits[4 * i +: 4]) diff = 1'b1;
          end
          if (key_fill - 1 != int'(want)) r.reason = FAIL_LENGTH;
          else if (diff) r.reason = FAIL_PIN;
          else r.action = ACT_DOOR;
        end
        if (r.reason != FAIL_NONE) begin
          if (fail_count != FAIL_MAX) fail_count++;
          if (fail_count >= lock_cfg.attempt_limit) lock_flag = 1'b1;
          r.status = ST_REJECTED;
        end else begin
          r.status = ST_ACCEPTED;
        end
        clear_entry();
      end else if (key_fill < KeyDepth) begin
        key_store[key_fill] = code[3:0];
        key_fill++;
        r.status = ST_STORED;
      end else begin
        clear_entry();
        r.status = ST_OVERFLOW;
      end
    end
    r.locked = lock_flag;
    r.count  = fail_count;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  // sender: offers the next pending transaction, idles at random
  always @(negedge clk_i) begin
    keypad_item_t it;
    if (!in_valid_i || in_took) begin
      in_took = 1'b0;
      if (pending_keys.size() != 0 && (calm || $urandom_range(99) >= 30)) begin
        it = pending_keys.pop_front();
        in_valid_i   <= 1'b1;
        opcode_i     <= it.op;
        event_code_i <= it.code;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_start) begin
      hold_start = 1'b0;
      hold_left  = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 30);
    end
  end

  // monitor: checks accepted results, then predicts for accepted inputs
  always @(posedge clk_i) begin : monitor
    lock_result_t want_r;
    bit           busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (out_valid_o && out_ready_i) begin
        busy = 1'b1;
        results_n++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_n));
        end else begin
          want_r = expected_results.pop_front();
          if (status_o !== want_r.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      results_n, status_o, want_r.status));
          if (action_o !== want_r.action)
            report_mismatch($sformatf("result %0d action %0d, expected %0d",
                                      results_n, action_o, want_r.action));
          if (fail_reason_o !== want_r.reason)
            report_mismatch($sformatf("result %0d fail_reason %0d, expected %0d",
                                      results_n, fail_reason_o, want_r.reason));
          if (locked_out_o !== want_r.locked)
            report_mismatch($sformatf("result %0d locked_out %0d, expected %0d",
                                      results_n, locked_out_o, want_r.locked));
          if (failed_count_o !== want_r.count)
            report_mismatch($sformatf("result %0d failed_count %0d, expected %0d",
                                      results_n, failed_count_o, want_r.count));
        end
      end
      if (in_valid_i && in_ready_o) begin
        busy = 1'b1;
        want_r = step_lock(opcode_i, event_code_i);
        status_seen[want_r.status]++;
        expected_results.push_back(want_r);
        accepted_n++;
        in_took = 1'b1;
      end
      if (psel && penable) busy = 1'b1;
      stall_cycles = busy ? 0 : stall_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (stall_cycles >= StallLimit);
    $display("no transaction for %0d cycles, %0d results still expected",
             stall_cycles, expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  // checked at the rising edge, where the sender's outputs are settled
  task automatic wait_idle();
    while (pending_keys.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PIN_ENABLE:    lock_cfg.pin_enable       = value[0];
      REG_PIN_LENGTH:    lock_cfg.pin_length       = value[PinLenW-1:0];
      REG_PIN_DIGITS:    lock_cfg.pin_digits       = value;
      REG_TIMEOUT_LIMIT: lock_cfg.timeout_limit_ms = value[ElapsedW-1:0];
      REG_ATTEMPT_LIMIT: lock_cfg.attempt_limit    = value[FailW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic en, input logic [3:0] len, input logic [31:0] digits,
                            input logic [14:0] tmo, input logic [7:0] att);
    wait_idle();
    write_reg(REG_PIN_ENABLE, {31'd0, en});
    write_reg(REG_PIN_LENGTH, {28'd0, len});
    write_reg(REG_PIN_DIGITS, digits);
    write_reg(REG_TIMEOUT_LIMIT, {17'd0, tmo});
    write_reg(REG_ATTEMPT_LIMIT, {24'd0, att});
    settings_n++;
  endtask

  task automatic push_item(input logic [1:0] op, input logic [7:0] code);
    pending_keys.push_back('{op: op, code: code});
    pushed_n++;
  endtask

  // a key press, sometimes preceded by a burst of millisecond ticks
  task automatic push_key(input logic [3:0] key);
    int n;
    if ($urandom_range(99) < 20) begin
      n = $urandom_range(1, 6);
      repeat (n) push_item(OP_TICK, 8'($urandom_range(255)));
    end
    push_item(OP_EVENT, {4'd0, key});
  endtask

  task automatic add_command();
    int         kind;
    int         n;
    int         bad;
    logic [3:0] want;
    logic [3:0] key;
    kind = $urandom_range(99);
    want = (lock_cfg.pin_length > PinMaxDef) ? 4'(PinMaxDef) : lock_cfg.pin_length;
    if (kind < 6) begin
      case ($urandom_range(2))
        0: push_item(OpSpare, 8'($urandom_range(255)));
        1: push_item(OP_EVENT, 8'($urandom_range(16, 255)));
        default: push_item(OP_TICK, 8'($urandom_range(255)));
      endcase
    end else if (kind < 9) begin
      push_item(OP_RESET, 8'($urandom_range(255)));
    end else if (kind < 20) begin
      push_key(CODE_STAR);
      push_key(DIGIT_LIGHT);
      push_key(CODE_HASH);
    end else if (kind < 32) begin
      push_key(CODE_STAR);
      push_key(DIGIT_DOOR);
      push_key(CODE_HASH);
    end else if (kind < 68) begin
      // right pin, or one digit off
      bad = (kind < 55 || want == 0) ? -1 : $urandom_range(int'(want) - 1);
      push_key(CODE_STAR);
      for (int i = 0; i < int'(want); i++) begin
        key = lock_cfg.pin_digits[4 * i +: 4];
        if (i == bad) key = key ^ 4'($urandom_range(1, 15));
        push_key(key);
      end
      push_key(CODE_HASH);
    end else if (kind < 82) begin
      n = $urandom_range(0, 9);
      push_key(CODE_STAR);
      repeat (n) push_key(4'($urandom_range(9)));
      push_key(CODE_HASH);
    end else begin
      // free-form codes, long enough at times to overflow the store
      n = $urandom_range(0, 17);
      repeat (n) push_key(4'($urandom_range(15)));
      push_key(CODE_HASH);
    end
  endtask

  task automatic add_random(input int n_items);
    int target;
    target = pushed_n + n_items;
    while (pushed_n < target) add_command();
  endtask

  initial begin
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_EVENT;
    event_code_i = '0;
    out_ready_i  = 1'b0;
    lock_cfg     = '{pin_enable: 1'b0, pin_length: '0, pin_digits: '0,
                     timeout_limit_ms: TIMEOUT_RESET, attempt_limit: ATTEMPT_RESET};
    fail_count   = '0;
    lock_flag    = 1'b0;
    clear_entry();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: pin off, three attempts
    push_item(OP_TICK, 8'hA5);
    push_item(OpSpare, 8'hFF);
    push_item(OP_EVENT, 8'd16);
    push_item(OP_EVENT, 8'hFF);
    push_key(CODE_HASH);
    push_key(CODE_STAR); push_key(DIGIT_LIGHT); push_key(CODE_HASH);
    push_key(CODE_STAR); push_key(DIGIT_DOOR);  push_key(CODE_HASH);
    push_key(CODE_STAR); push_key(4'd5);        push_key(CODE_HASH);
    push_key(4'd7); push_key(CODE_HASH);
    push_key(4'd4);
    push_item(OP_RESET, 8'h5A);
    push_key(CODE_STAR); push_key(DIGIT_DOOR); push_key(DIGIT_DOOR); push_key(CODE_HASH);

    // star-two wins even when it is also the pin
    set_config(1'b1, 4'd1, 32'h0000_0002, 15'd10000, 8'd3);
    push_key(CODE_STAR); push_key(DIGIT_LIGHT); push_key(CODE_HASH);
    push_key(CODE_STAR); push_key(4'd3);        push_key(CODE_HASH);
    push_key(CODE_STAR); push_key(CODE_HASH);

    set_config(1'b1, 4'd4, $urandom, 15'd20, 8'd255);
    add_random(300);

    // zero timeout and zero-length pin
    set_config(1'b1, 4'd0, $urandom, 15'd0, 8'd4);
    add_random(150);

    // receiver holds off while the sender keeps offering
    set_config(1'b1, 4'd8, $urandom, 15'd30000, 8'd0);
    add_random(250);
    @(posedge clk_i);
    hold_start = 1'b1;

    set_config(1'b1, 4'd15, $urandom, 15'd5000, 8'd5);
    add_random(200);

    // failure count up to the largest limit, no idling on either side
    set_config(1'b0, 4'd9, $urandom, 15'd7, 8'd255);
    calm = 1'b1;
    repeat (260) push_key(CODE_HASH);
    add_random(150);
    wait_idle();
    calm = 1'b0;

    set_config(1'b0, 4'd0, 32'h0, 15'd1, 8'd1);
    add_random(150);

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d transactions and %0d results over %0d register settings",
             accepted_n, results_n, settings_n);
    $display("stored %0d, accepted %0d, rejected %0d, timed out %0d, overflow %0d, ignored %0d",
             status_seen[ST_STORED], status_seen[ST_ACCEPTED], status_seen[ST_REJECTED],
             status_seen[ST_TIMEOUT], status_seen[ST_OVERFLOW], status_seen[ST_IGNORED]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/dpcl_pkg.sv
rtl/core/dpcl_cfg.sv
rtl/core/dpcl_judge.sv
rtl/core/dpcl_core.sv
rtl/core/dtmf_pin_command_lock.sv
test/testbench.sv
